// File: rtl/core/htrd_pkg.sv
// ----------------------------------------------------------------------------
// htrd_pkg
// Types and constants shared by the reading decoder modules.
// ----------------------------------------------------------------------------
package htrd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] check_byte;
    logic       bus_error;
  } in_t;

  typedef struct packed {
    logic              kind_out;
    logic signed [11:0] value;
    logic              crc_fail;
    logic              bus_fail;
  } out_t;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_HUMID = 1'b1;

  // x^(i+8) mod x^8+x^5+x^4+1 for bit i of the 16-bit data word
  localparam logic [7:0] CRC_TERM [16] = '{
    8'h31, 8'h62, 8'hC4, 8'hB9, 8'h43, 8'h86, 8'h3D, 8'h7A,
    8'hF4, 8'hD9, 8'h83, 8'h37, 8'h6E, 8'hDC, 8'h89, 8'h23
  };

  localparam int WORD_W  = 14;
  localparam int MUL_W   = 30;
  localparam int PROD_W  = WORD_W + MUL_W;
  localparam int Q_SHIFT = 32;
  localparam int Q_W     = PROD_W - Q_SHIFT;
  localparam int HQ_W    = 7;

  // ceil(2^32 * 2048 / 9548) and ceil(2^32 * 1024 / 134215)
  localparam logic [MUL_W-1:0] MUL_TEMP  = 30'd921249793;
  localparam logic [MUL_W-1:0] MUL_HUMID = 30'd32768667;

  localparam logic signed [Q_W:0]  TEMP_OFFSET  = 13'sd937;
  localparam logic signed [11:0]   HUMID_OFFSET = 12'sd6;

endpackage

// File: rtl/core/htrd_if.sv
// ----------------------------------------------------------------------------
// htrd_if
// Valid/ready channels carrying a reading request and a decoded result.
// ----------------------------------------------------------------------------
interface htrd_in_if;
  logic         valid;
  logic         ready;
  htrd_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface htrd_out_if;
  logic          valid;
  logic          ready;
  htrd_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/humidity_temp_reading_decoder_core.sv
// ----------------------------------------------------------------------------
// humidity_temp_reading_decoder_core
// Decodes sensor readings: CRC-8 check and conversion to physical units.
//
// Input channel in_chan carries one reading request: kind, the two data
// bytes, the check byte and the bus error flag. Output channel out_chan
// returns one result per request: kind echo, signed value (tenths of a
// degree, or whole percent), CRC failure and bus failure flags.
// A request is taken into an input register, decoded by the CRC network
// and one shared 14x30 constant multiplier, and held in a result register.
// out_chan.valid rises once a request has moved from the input register
// into the result register; one request is accepted every cycle while the
// receiver does not stall, each taking a single pass through that multiplier.
// When the receiver stalls, the result register holds and the input
// register fills; in_chan.ready drops only once both are occupied.
// Reset (rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
module humidity_temp_reading_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  htrd_in_if.sink           in_chan,
  htrd_out_if.source        out_chan
);
  import htrd_pkg::*;

  logic          s1_valid_r;
  in_t           s1_data_r;
  logic          s2_valid_r;
  out_t          s2_data_r;
  logic          s1_ready;
  logic          s2_ready;
  logic          crc_fail;
  logic signed [11:0] value;
  out_t          s2_data_nxt;

  assign s2_ready = !s2_valid_r || out_chan.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign in_chan.ready  = s1_ready;
  assign out_chan.valid = s2_valid_r;
  assign out_chan.data  = s2_data_r;

  htrd_crc_check u_crc (
    .data_high  (s1_data_r.data_high),
    .data_low   (s1_data_r.data_low),
    .check_byte (s1_data_r.check_byte),
    .crc_fail   (crc_fail)
  );

  htrd_convert u_conv (
    .kind     (s1_data_r.kind),
    .word     ({s1_data_r.data_high, s1_data_r.data_low[7:2]}),
    .crc_fail (crc_fail),
    .value    (value)
  );

  always_comb begin
    s2_data_nxt.kind_out = s1_data_r.kind;
    s2_data_nxt.value    = value;
    s2_data_nxt.crc_fail = crc_fail;
    s2_data_nxt.bus_fail = s1_data_r.bus_error;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_data_r <= in_chan.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_data_r.crc_fail) |-> (s2_data_r.value == 12'sd0))
    else $error("value not cleared on CRC failure");

  a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_data_r.kind_out == KIND_HUMID)
      |-> (s2_data_r.value >= -12'sd6 && s2_data_r.value <= 12'sd118))
    else $error("humidity result out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register dropped a stalled request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !s2_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// File: rtl/core/htrd_crc_check.sv
// ----------------------------------------------------------------------------
// htrd_crc_check
// CRC-8 over the two data bytes, compared against the check byte.
// ----------------------------------------------------------------------------
module htrd_crc_check (
  input  logic [7:0] data_high,
  input  logic [7:0] data_low,
  input  logic [7:0] check_byte,
  output logic       crc_fail
);
  import htrd_pkg::*;

  logic [15:0] word;
  logic [7:0]  crc;

  assign word = {data_high, data_low};

  always_comb begin
    crc = 8'h00;
    for (int i = 0; i < 16; i++) begin
      if (word[i]) begin
        crc = crc ^ CRC_TERM[i];
      end
    end
  end

  assign crc_fail = (crc != check_byte);

endmodule

// File: rtl/core/htrd_convert.sv
// ----------------------------------------------------------------------------
// htrd_convert
// Scales the masked raw word to tenths of a degree or percent humidity.
// ----------------------------------------------------------------------------
module htrd_convert (
  input  logic                          kind,
  input  logic [htrd_pkg::WORD_W-1:0]   word,
  input  logic                          crc_fail,
  output logic signed [11:0]            value
);
  import htrd_pkg::*;

  logic [MUL_W-1:0]   mul_k;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     quot;
  logic signed [Q_W:0] temp_diff;
  logic signed [Q_W:0] temp_half;
  logic signed [11:0] humid_val;

  assign mul_k = (kind == KIND_HUMID) ? MUL_HUMID : MUL_TEMP;
  assign prod  = PROD_W'(word) * PROD_W'(mul_k);
  assign quot  = prod[PROD_W-1:Q_SHIFT];

  // halve toward zero
  assign temp_diff = $signed({1'b0, quot}) - TEMP_OFFSET;
  assign temp_half = (temp_diff + $signed({{Q_W{1'b0}}, temp_diff[Q_W]})) >>> 1;

  assign humid_val = $signed({{(12-HQ_W){1'b0}}, quot[HQ_W-1:0]}) - HUMID_OFFSET;

  always_comb begin
    if (crc_fail) begin
      value = 12'sd0;
    end else if (kind == KIND_HUMID) begin
      value = humid_val;
    end else begin
      value = temp_half[11:0];
    end
  end

endmodule
